[rtl/core/mrrp_pkg.sv]
`default_nettype none

package mrrp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned KIND_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] ADDR_RESET = 8'h01;
    localparam logic [BYTE_W-1:0] FN_READ_INPUTS = 8'h02;
    localparam logic [BYTE_W-1:0] FN_READ_HOLDING = 8'h03;
    localparam logic [BYTE_W-1:0] SW_BYTE_COUNT = 8'h01;
    localparam logic [BYTE_W-1:0] VAL_BYTE_COUNT = 8'h06;
    localparam logic [BYTE_W-1:0] VAL_PAD_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] SEL_TEMPERATURE = 8'h01;
    localparam logic [BYTE_W-1:0] SEL_HUMIDITY = 8'h02;

    localparam logic [KIND_W-1:0] KIND_SWITCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEMPERATURE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HUMIDITY = 2'd2;

    localparam int unsigned OUT_DATA_W = BYTE_W + VALUE_W;
    localparam int unsigned OUT_USER_W = KIND_W + 1;

endpackage

`default_nettype wire

[rtl/core/mrrp_crc16_byte.sv]
`default_nettype none

module mrrp_crc16_byte
    import mrrp_pkg::*;
(
    input  wire logic [CRC_W-1:0]  i_crc,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic [CRC_W-1:0]       o_crc
);

    always_comb begin
        logic [CRC_W-1:0] c;
        c = i_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

[rtl/core/modbus_rtu_response_parser.sv]
// Modbus RTU response parser.
// The slave stream takes one received byte per word in s_axis_tdata. Frames
// begin with the station address, then either function 0x02 with one switch
// byte or function 0x03 with a temperature or humidity value, then two CRC
// bytes. A byte that does not fit the frame returns the parser to idle and is
// dropped. The master stream gives one word per frame, on its last CRC byte.
// The station address is written through i_cfg_wr_en and i_cfg_wr_data; the
// user must do so only while no frame is in flight, which the block does not
// enforce; it resets to 1. While s_axis_tready is high, one byte is taken in
// every cycle: the CRC update and the parser step are one pass of logic
// between the parser state registers and the result register. When the
// receiver stalls, the result register holds its word and s_axis_tready
// stays high for bytes that do not complete a frame's result while the
// register is full; it drops only when a new result would overwrite an
// untaken one. Reset clears the parser to idle, the running CRC to 0xFFFF
// and the result register to empty.
`default_nettype none

module modbus_rtu_response_parser
    import mrrp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [BYTE_W-1:0]     i_cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // rx_byte
    input  wire logic [BYTE_W-1:0]     s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // switch_bits [7:0], value_word [39:8]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // frame_kind [1:0], crc_ok [2]
    output logic [OUT_USER_W-1:0]      m_axis_tuser
);

    typedef enum logic [3:0] {
        P_IDLE      = 4'd0,
        P_FUNC      = 4'd1,
        P_SW_COUNT  = 4'd2,
        P_SW_DATA   = 4'd3,
        P_SW_CRC1   = 4'd4,
        P_SW_CRC2   = 4'd5,
        P_VAL_COUNT = 4'd6,
        P_VAL_ZERO  = 4'd7,
        P_VAL_SEL   = 4'd8,
        P_VAL_B1    = 4'd9,
        P_VAL_B2    = 4'd10,
        P_VAL_B3    = 4'd11,
        P_VAL_B4    = 4'd12,
        P_VAL_CRC1  = 4'd13,
        P_VAL_CRC2  = 4'd14
    } t_pos;

    t_pos               r_pos, n_pos;
    logic [CRC_W-1:0]   r_crc, n_crc;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [BYTE_W-1:0]  r_switches, n_switches;
    logic [BYTE_W-1:0]  r_crc_lo, n_crc_lo;
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [BYTE_W-1:0]  r_station;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;

    logic               s_fire;
    logic               done;
    logic [CRC_W-1:0]   crc_base;
    logic [CRC_W-1:0]   crc_fed;
    logic               crc_match;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign done = (r_pos == P_SW_CRC2) || (r_pos == P_VAL_CRC2);
    assign s_axis_tready = !r_out_valid || m_axis_tready || !done;
    assign crc_base = (r_pos == P_IDLE) ? CRC_INIT : r_crc;
    assign crc_match = (r_crc_lo == r_crc[BYTE_W-1:0]) &&
                       (s_axis_tdata == r_crc[CRC_W-1:BYTE_W]);

    mrrp_crc16_byte u_crc (
        .i_crc  (crc_base),
        .i_byte (s_axis_tdata),
        .o_crc  (crc_fed)
    );

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_value = r_value;
        n_switches = r_switches;
        n_crc_lo = r_crc_lo;
        n_kind = r_kind;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;
        if (s_fire) begin
            n_pos = P_IDLE;
            n_crc = CRC_INIT;
            case (r_pos)
                P_FUNC: begin
                    if (s_axis_tdata == FN_READ_INPUTS) begin
                        n_pos = P_SW_COUNT;
                        n_crc = crc_fed;
                    end else if (s_axis_tdata == FN_READ_HOLDING) begin
                        n_pos = P_VAL_COUNT;
                        n_crc = crc_fed;
                    end
                end
                P_SW_COUNT: begin
                    if (s_axis_tdata == SW_BYTE_COUNT) begin
                        n_pos = P_SW_DATA;
                        n_crc = crc_fed;
                    end
                end
                P_SW_DATA: begin
                    n_switches = s_axis_tdata;
                    n_pos = P_SW_CRC1;
                    n_crc = crc_fed;
                end
                P_SW_CRC1: begin
                    n_crc_lo = s_axis_tdata;
                    n_pos = P_SW_CRC2;
                    n_crc = r_crc;
                end
                P_VAL_CRC1: begin
                    n_crc_lo = s_axis_tdata;
                    n_pos = P_VAL_CRC2;
                    n_crc = r_crc;
                end
                P_VAL_COUNT: begin
                    if (s_axis_tdata == VAL_BYTE_COUNT) begin
                        n_pos = P_VAL_ZERO;
                        n_crc = crc_fed;
                    end
                end
                P_VAL_ZERO: begin
                    if (s_axis_tdata == VAL_PAD_BYTE) begin
                        n_pos = P_VAL_SEL;
                        n_crc = crc_fed;
                    end
                end
                P_VAL_SEL: begin
                    if (s_axis_tdata == SEL_TEMPERATURE) begin
                        n_kind = KIND_TEMPERATURE;
                        n_pos = P_VAL_B1;
                        n_crc = crc_fed;
                    end else if (s_axis_tdata == SEL_HUMIDITY) begin
                        n_kind = KIND_HUMIDITY;
                        n_pos = P_VAL_B1;
                        n_crc = crc_fed;
                    end
                end
                P_VAL_B1: begin
                    n_value[15:8] = s_axis_tdata;
                    n_pos = P_VAL_B2;
                    n_crc = crc_fed;
                end
                P_VAL_B2: begin
                    n_value[7:0] = s_axis_tdata;
                    n_pos = P_VAL_B3;
                    n_crc = crc_fed;
                end
                P_VAL_B3: begin
                    n_value[31:24] = s_axis_tdata;
                    n_pos = P_VAL_B4;
                    n_crc = crc_fed;
                end
                P_VAL_B4: begin
                    n_value[23:16] = s_axis_tdata;
                    n_pos = P_VAL_CRC1;
                    n_crc = crc_fed;
                end
                P_SW_CRC2: begin
                    n_out_valid = 1'b1;
                    n_out_data = {{VALUE_W{1'b0}}, r_switches};
                    n_out_user = {crc_match, KIND_SWITCH};
                end
                P_VAL_CRC2: begin
                    n_out_valid = 1'b1;
                    n_out_data = {r_value, {BYTE_W{1'b0}}};
                    n_out_user = {crc_match, r_kind};
                end
                default: begin
                    if (s_axis_tdata == r_station) begin
                        n_pos = P_FUNC;
                        n_crc = crc_fed;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= P_IDLE;
            r_crc <= CRC_INIT;
            r_out_valid <= 1'b0;
            r_station <= ADDR_RESET;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_station <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_switches <= n_switches;
        r_crc_lo <= n_crc_lo;
        r_kind <= n_kind;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_out_data;
    assign m_axis_tuser = r_out_user;

    a_result_follows_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && done) |=> m_axis_tvalid)
        else $error("frame end gave no result word");

    a_idle_after_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && done) |=> (r_pos == P_IDLE && r_crc == CRC_INIT))
        else $error("parser not idle after frame end");

    a_idle_crc_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == P_IDLE) |-> (r_crc == CRC_INIT))
        else $error("running CRC not initial while idle");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[KIND_W-1:0] != 2'd3))
        else $error("undefined frame kind on output");

    a_switch_word_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[KIND_W-1:0] == KIND_SWITCH) |->
        (m_axis_tdata[OUT_DATA_W-1:BYTE_W] == '0))
        else $error("switch word carries a value");

endmodule

`default_nettype wire
